// ===== sv/indexed_list_store_assert.svh =====
// ----------------------------------------------------------------------------
// indexed_list_store_assert.svh
// Assertion macros shared by the list store RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ILS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== sv/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Types and constants of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 64;
  // Widest cell index over the supported capacity range (up to 1024 entries).
  localparam int unsigned MAX_IDX_W        = 10;
  localparam int unsigned VALUE_W          = 32;

  typedef enum logic [2:0] {
    FUNC_READ     = 3'd0,
    FUNC_INS_HEAD = 3'd1,
    FUNC_APPEND   = 3'd2,
    FUNC_INS_POS  = 3'd3,
    FUNC_DELETE   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [7:0]  position;
    logic signed [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic [1:0]         status;
    logic [6:0]         list_length;
  } result_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_e               op;
    logic [MAX_IDX_W-1:0]   pos;
    logic                   read_en;
    logic [VALUE_W-1:0]     value;
  } cell_ctrl_t;

endpackage

// ===== sv/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds an entry, shifts with its neighbors on insert and
// delete, and presents its entry when a read selects it.
// ----------------------------------------------------------------------------
module ils_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                         clk_i,
  input  ils_pkg::cell_ctrl_t          ctrl_i,
  input  logic [ils_pkg::VALUE_W-1:0]  prev_i,
  input  logic [ils_pkg::VALUE_W-1:0]  next_i,
  output logic [ils_pkg::VALUE_W-1:0]  entry_o,
  output logic [ils_pkg::VALUE_W-1:0]  read_o
);

  localparam logic [ils_pkg::MAX_IDX_W-1:0] MY_IDX = ils_pkg::MAX_IDX_W'(IDX);

  logic [ils_pkg::VALUE_W-1:0] entry_q, entry_d;
  logic [ils_pkg::VALUE_W-1:0] read_q, read_d;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      ils_pkg::CELL_INS: begin
        if (MY_IDX > ctrl_i.pos) begin
          entry_d = prev_i;
        end else if (MY_IDX == ctrl_i.pos) begin
          entry_d = ctrl_i.value;
        end
      end
      ils_pkg::CELL_DEL: begin
        if (MY_IDX >= ctrl_i.pos) begin
          entry_d = next_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // Read from the entry as it was before this transfer.
  assign read_d = (ctrl_i.read_en && (MY_IDX == ctrl_i.pos)) ? entry_q : '0;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    read_q  <= read_d;
  end

  assign entry_o = entry_q;
  assign read_o  = read_q;

endmodule

// ===== sv/ils_or_tree.sv =====
// ----------------------------------------------------------------------------
// ils_or_tree
// Pipelined OR reduction of the cell read outputs. A register sits every
// third level and at the root.
// ----------------------------------------------------------------------------
module ils_or_tree #(
  parameter int unsigned LEAVES = ils_pkg::DEFAULT_CAPACITY,
  parameter int unsigned WIDTH  = ils_pkg::VALUE_W
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] leaf_i [LEAVES],
  output logic [WIDTH-1:0] root_o
);

  localparam int unsigned LOG2P = $clog2(LEAVES);
  localparam int unsigned P     = 1 << LOG2P;

  // Heap order: node 1 is the root, nodes P to 2P-1 are the leaves.
  logic [WIDTH-1:0] node [1:2*P-1];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < LEAVES) begin : g_used
      assign node[P+j] = leaf_i[j];
    end else begin : g_pad
      assign node[P+j] = '0;
    end
  end

  for (genvar i = 1; i < P; i++) begin : g_node
    localparam int unsigned HGT = LOG2P - ($clog2(i + 1) - 1);
    logic [WIDTH-1:0] node_d;
    assign node_d = node[2*i] | node[2*i+1];
    if ((HGT % 3 == 0) || (HGT == LOG2P)) begin : g_reg
      logic [WIDTH-1:0] node_q;
      always_ff @(posedge clk_i) begin
        node_q <= node_d;
      end
      assign node[i] = node_q;
    end else begin : g_comb
      assign node[i] = node_d;
    end
  end

  assign root_o = node[1];

endmodule

// ===== sv/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit values kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd_i and raise start_i; the command transfers at a rising edge
//   with start_i high and busy_o low. busy_o stays low, so a command may
//   be issued every cycle: insert and delete shift all cells in parallel
//   in the transfer cycle, and the next command sees the updated list.
//   Each command yields one result on result_o, marked by valid_o for one
//   cycle, once its read has passed the cell read register and the TREE_LAT
//   register levels of the OR tree that gathers a read from the cells:
//   ceil(log2(CAPACITY) / 3), which is 2 for 64 entries. Results leave in
//   command order, one per cycle at most; the receiver cannot stall them.
//   Reset clears the length and the valid pipeline; entry contents are
//   not cleared and are only read below the current length.
//   An insert into a full list with a valid position is dropped with status
//   full; list_length carries the low 7 bits of the count after the command.
// ----------------------------------------------------------------------------
`include "indexed_list_store_assert.svh"

module indexed_list_store #(
  parameter int unsigned CAPACITY = ils_pkg::DEFAULT_CAPACITY
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  ils_pkg::cmd_t    cmd_i,
  output logic             valid_o,
  output ils_pkg::result_t result_o
);

  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W    = (CNT_W > 7) ? CNT_W : 7;
  localparam int unsigned LOG2P    = $clog2(CAPACITY);
  localparam int unsigned TREE_LAT = LOG2P / 3 + ((LOG2P % 3 != 0) ? 1 : 0);

  typedef struct packed {
    logic       fail;
    logic       found;
    logic [1:0] status;
    logic [6:0] length;
  } side_t;

  logic                accept;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                pos_neg, in_range, full;
  logic [CMP_W-1:0]    pos_c, cnt_c, ins_pos;
  ils_pkg::status_e    status;
  logic                found, fail;
  ils_pkg::cell_ctrl_t ctrl;

  logic [ils_pkg::VALUE_W-1:0] entry  [CAPACITY];
  logic [ils_pkg::VALUE_W-1:0] rd_val [CAPACITY];
  logic [ils_pkg::VALUE_W-1:0] root;

  logic  vld_q  [TREE_LAT+1];
  side_t side_q [TREE_LAT+1];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign pos_neg  = cmd_i.position[7];
  assign pos_c    = CMP_W'(cmd_i.position[6:0]);
  assign cnt_c    = CMP_W'(count_q);
  assign in_range = !pos_neg && (pos_c < cnt_c);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign ins_pos  = pos_neg ? '0 : pos_c;

  always_comb begin
    status       = ils_pkg::ST_DONE;
    found        = 1'b0;
    fail         = 1'b0;
    count_d      = count_q;
    ctrl.op      = ils_pkg::CELL_HOLD;
    ctrl.pos     = ils_pkg::MAX_IDX_W'(pos_c);
    ctrl.read_en = 1'b0;
    ctrl.value   = cmd_i.item_value;
    case (cmd_i.func)
      ils_pkg::FUNC_READ: begin
        if (in_range) begin
          found        = 1'b1;
          ctrl.read_en = accept;
        end else begin
          fail   = 1'b1;
          status = ils_pkg::ST_INVALID;
        end
      end
      ils_pkg::FUNC_INS_HEAD: begin
        ctrl.pos = '0;
        if (full) begin
          status = ils_pkg::ST_FULL;
        end else begin
          ctrl.op = ils_pkg::CELL_INS;
        end
      end
      ils_pkg::FUNC_APPEND: begin
        ctrl.pos = ils_pkg::MAX_IDX_W'(count_q);
        if (full) begin
          status = ils_pkg::ST_FULL;
        end else begin
          ctrl.op = ils_pkg::CELL_INS;
        end
      end
      ils_pkg::FUNC_INS_POS: begin
        ctrl.pos = ils_pkg::MAX_IDX_W'(ins_pos);
        // Position check wins over the full check.
        if (ins_pos > cnt_c) begin
          status = ils_pkg::ST_INVALID;
        end else if (full) begin
          status = ils_pkg::ST_FULL;
        end else begin
          ctrl.op = ils_pkg::CELL_INS;
        end
      end
      ils_pkg::FUNC_DELETE: begin
        if (in_range) begin
          ctrl.op = ils_pkg::CELL_DEL;
        end else begin
          status = ils_pkg::ST_INVALID;
        end
      end
      default: status = ils_pkg::ST_INVALID;
    endcase
    if (!accept) begin
      ctrl.op = ils_pkg::CELL_HOLD;
    end
    if (ctrl.op == ils_pkg::CELL_INS) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.op == ils_pkg::CELL_DEL) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ils_pkg::VALUE_W-1:0] prev, next;
    if (i == 0) begin : g_head
      assign prev = cmd_i.item_value;
    end else begin : g_body
      assign prev = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next = entry[i];
    end else begin : g_mid
      assign next = entry[i+1];
    end
    ils_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .prev_i  (prev),
      .next_i  (next),
      .entry_o (entry[i]),
      .read_o  (rd_val[i])
    );
  end

  ils_or_tree #(
    .LEAVES (CAPACITY),
    .WIDTH  (ils_pkg::VALUE_W)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (rd_val),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k <= TREE_LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      count_q  <= count_d;
      vld_q[0] <= accept;
      for (int k = 1; k <= TREE_LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Carry the result fields alongside the read tree.
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{fail: fail, found: found, status: status, length: 7'(count_d)};
    for (int k = 1; k <= TREE_LAT; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o              = vld_q[TREE_LAT];
  assign result_o.read_value  = side_q[TREE_LAT].fail ? '1 : root;
  assign result_o.found       = side_q[TREE_LAT].found;
  assign result_o.status      = side_q[TREE_LAT].status;
  assign result_o.list_length = side_q[TREE_LAT].length;

  `ILS_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(CAPACITY))
  `ILS_ASSERT_NXT(a_full_keeps, clk_i, rst_ni, accept && (status == ils_pkg::ST_FULL), $stable(count_q))
  `ILS_ASSERT_IMP(a_result_src, clk_i, rst_ni, valid_o, $past(accept, TREE_LAT + 1))
  `ILS_ASSERT_IMP(a_found_done, clk_i, rst_ni, valid_o && result_o.found, result_o.status == ils_pkg::ST_DONE)

endmodule
